// ===== rtl/core/dbsc_pkg.sv =====
// dbsc_pkg: shared widths, register indexes, reset values and types for the
// disk block to seek command translator. No dependencies.
package dbsc_pkg;

  localparam int NUM_DRIVES_DEF = 4;
  localparam int BLOCK_BITS_DEF = 16;

  localparam int DRIVE_W    = 2;
  localparam int TRACK_W    = 11;
  localparam int HEADS_W    = 4;
  localparam int SECT_W     = 8;
  localparam int ROT_W      = 10;
  localparam int CYL_W      = 10;
  localparam int HEAD_W     = 3;
  localparam int PERCYL_W   = 12;
  localparam int TOTAL_W    = 23;
  localparam int DIVISOR_W  = 12;
  localparam int SHORT_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int SEL_W      = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TRACK_COUNT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_COUNT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_TRACK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CYLINDER_ROTATION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRECOMP_TRACK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_CURRENT_TRACK = 3'd5;

  localparam logic [TRACK_W-1:0] TRACK_COUNT_RST       = 11'd306;
  localparam logic [HEADS_W-1:0] HEAD_COUNT_RST        = 4'd4;
  localparam logic [SECT_W-1:0]  SECTORS_PER_TRACK_RST = 8'd17;
  localparam logic [ROT_W-1:0]   CYLINDER_ROTATION_RST = 10'd153;
  localparam logic [TRACK_W-1:0] PRECOMP_TRACK_RST     = 11'd128;
  localparam logic [TRACK_W-1:0] LOW_CURRENT_TRACK_RST = 11'd128;

  typedef struct packed {
    logic [TRACK_W-1:0] track_count;
    logic [HEADS_W-1:0] head_count;
    logic [SECT_W-1:0]  sectors_per_track;
    logic [ROT_W-1:0]   cylinder_rotation;
    logic [TRACK_W-1:0] precomp_track;
    logic [TRACK_W-1:0] low_current_track;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic short_run;
  } div_ctl_t;

endpackage

// ===== rtl/core/dbsc_fifo.sv =====
// dbsc_fifo: short queue between the classifying front and the executing back.
// Depends on dbsc_pkg for the default depth.
module dbsc_fifo import dbsc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/dbsc_front.sv =====
// dbsc_front: takes a request, forms the geometry products and classifies it
// as in range or rejected before queueing it. Depends on dbsc_pkg.
module dbsc_front import dbsc_pkg::*; #(
  parameter int NUM_DRIVES = NUM_DRIVES_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [DRIVE_W-1:0]      drive_i,
  input  logic [BLOCK_BITS-1:0]   block_i,
  input  logic                    full_i,
  output logic                    push_o,
  output logic [BLOCK_BITS+2:0]   push_data_o
);

  localparam int CmpW = (BLOCK_BITS > TOTAL_W) ? BLOCK_BITS : TOTAL_W;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL1,
    F_MUL2,
    F_PUSH
  } state_e;

  state_e                 state_q;
  logic [DRIVE_W-1:0]     drive_q;
  logic [BLOCK_BITS-1:0]  block_q;
  logic [PERCYL_W-1:0]    per_cyl_q, per_cyl_d;
  logic [TOTAL_W-1:0]     total_q, total_d;
  logic                   reject;

  assign per_cyl_d = PERCYL_W'(cfg_i.head_count) * PERCYL_W'(cfg_i.sectors_per_track);
  assign total_d   = TOTAL_W'(per_cyl_q) * TOTAL_W'(cfg_i.track_count);

  assign reject = ({1'b0, drive_q} >= (DRIVE_W + 1)'(NUM_DRIVES)) ||
                  (total_q == '0) ||
                  (CmpW'(block_q) >= CmpW'(total_q));

  assign in_ready_o  = (state_q == F_IDLE);
  assign push_o      = (state_q == F_PUSH) && !full_i;
  assign push_data_o = {reject, drive_q, block_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            state_q <= F_MUL1;
          end
        end
        F_MUL1: state_q <= F_MUL2;
        F_MUL2: state_q <= F_PUSH;
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // request and geometry products
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      drive_q <= drive_i;
      block_q <= block_i;
    end
    if (state_q == F_MUL1) begin
      per_cyl_q <= per_cyl_d;
    end
    if (state_q == F_MUL2) begin
      total_q <= total_d;
    end
  end

endmodule

// ===== rtl/core/dbsc_div.sv =====
// dbsc_div: restoring divider, one quotient bit a cycle, full width or a
// short twelve-step run. Depends on dbsc_pkg for widths and the control type.
module dbsc_div import dbsc_pkg::*; #(
  parameter int DW = BLOCK_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_ctl_t             ctl_i,
  input  logic [DW-1:0]        dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [DW-1:0]        quotient_o,
  output logic [DIVISOR_W-1:0] remainder_o
);

  localparam int CntW = $clog2(DW + 1);

  logic                 busy_q, done_q;
  logic [CntW-1:0]      cnt_q;
  logic [DW-1:0]        quo_q;
  logic [DIVISOR_W-1:0] rem_q, dsr_q;
  logic [DIVISOR_W:0]   sh, diff;
  logic                 ge;

  assign sh   = {rem_q, quo_q[DW-1]};
  assign diff = sh - {1'b0, dsr_q};
  assign ge   = (sh >= {1'b0, dsr_q});

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctl_i.short_run ? CntW'(SHORT_W) : CntW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      quo_q <= ctl_i.short_run ? (DW'(dividend_i[SHORT_W-1:0]) << (DW - SHORT_W))
                               : dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIVISOR_W-1:0] : sh[DIVISOR_W-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/dbsc_back.sv =====
// dbsc_back: carries out queued requests: three divisions on the shared
// divider, seek against the stored track, result register. Depends on dbsc_pkg.
module dbsc_back import dbsc_pkg::*; #(
  parameter int NUM_DRIVES = NUM_DRIVES_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  empty_i,
  input  logic [BLOCK_BITS+2:0] entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_of_range_o,
  output logic [CYL_W-1:0]      cylinder_o,
  output logic [HEAD_W-1:0]     head_o,
  output logic [SECT_W-1:0]     sector_o,
  output logic [CYL_W-1:0]      steps_o,
  output logic                  step_out_o,
  output logic [SEL_W-1:0]      head_select_byte_o
);

  localparam int DW      = (BLOCK_BITS > SHORT_W) ? BLOCK_BITS : SHORT_W;
  localparam int DrvIdxW = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV1,
    B_DIV2,
    B_DIV3,
    B_FIN
  } state_e;

  state_e                 state_q;
  logic [CYL_W-1:0]       track_q [NUM_DRIVES];
  logic [PERCYL_W-1:0]    per_cyl_q;
  logic [DRIVE_W-1:0]     drive_q;
  logic                   reject_q;
  logic [DIVISOR_W-1:0]   r_q;
  logic [CYL_W-1:0]       cyl_q;
  logic [HEAD_W-1:0]      head_q;
  logic [SECT_W-1:0]      sector_q;

  logic                   out_valid_q, oor_q, step_out_q;
  logic [CYL_W-1:0]       cylinder_q, steps_q;
  logic [HEAD_W-1:0]      head_out_q;
  logic [SECT_W-1:0]      sector_out_q;
  logic [SEL_W-1:0]       sel_q;

  logic                   e_reject;
  logic [DRIVE_W-1:0]     e_drive;
  logic [BLOCK_BITS-1:0]  e_block;

  div_ctl_t               div_ctl;
  logic [DW-1:0]          div_dividend, div_quo;
  logic [DIVISOR_W-1:0]   div_divisor, div_rem;
  logic                   div_done;
  logic [SHORT_W-1:0]     rot_sum;

  logic [CYL_W-1:0]       cur, steps;
  logic                   up, precomp, high_cur, out_free;
  logic [SEL_W-1:0]       sel;

  assign e_reject = entry_i[BLOCK_BITS+2];
  assign e_drive  = entry_i[BLOCK_BITS+1:BLOCK_BITS];
  assign e_block  = entry_i[BLOCK_BITS-1:0];

  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign out_free = !out_valid_q || out_ready_i;

  assign rot_sum = SHORT_W'(div_quo[TRACK_W-1:0]) + SHORT_W'(cfg_i.cylinder_rotation);

  always_comb begin
    div_ctl      = '0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i && !e_reject) begin
          div_ctl.start = 1'b1;
          div_dividend  = DW'(e_block);
          div_divisor   = per_cyl_q;
        end
      end
      B_DIV1: begin
        if (div_done) begin
          div_ctl.start     = 1'b1;
          div_ctl.short_run = 1'b1;
          div_dividend      = DW'(rot_sum);
          div_divisor       = DIVISOR_W'(cfg_i.track_count);
        end
      end
      B_DIV2: begin
        if (div_done) begin
          div_ctl.start     = 1'b1;
          div_ctl.short_run = 1'b1;
          div_dividend      = DW'(r_q);
          div_divisor       = DIVISOR_W'(cfg_i.sectors_per_track);
        end
      end
      default: ;
    endcase
  end

  dbsc_div #(
    .DW(DW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (div_ctl),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // seek and head select
  assign cur      = track_q[drive_q[DrvIdxW-1:0]];
  assign up       = (cyl_q > cur);
  assign steps    = up ? (cyl_q - cur) : (cur - cyl_q);
  assign precomp  = ({1'b0, cyl_q} >= cfg_i.precomp_track);
  assign high_cur = ({1'b0, cyl_q} < cfg_i.low_current_track);
  assign sel      = {precomp, high_cur, 1'b0, ~head_q, drive_q};

  always_ff @(posedge clk_i) begin
    per_cyl_q <= PERCYL_W'(cfg_i.head_count) * PERCYL_W'(cfg_i.sectors_per_track);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      for (int i = 0; i < NUM_DRIVES; i++) begin
        track_q[i] <= '0;
      end
      drive_q      <= '0;
      reject_q     <= 1'b0;
      r_q          <= '0;
      cyl_q        <= '0;
      head_q       <= '0;
      sector_q     <= '0;
      out_valid_q  <= 1'b0;
      oor_q        <= 1'b0;
      cylinder_q   <= '0;
      head_out_q   <= '0;
      sector_out_q <= '0;
      steps_q      <= '0;
      step_out_q   <= 1'b0;
      sel_q        <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            drive_q  <= e_drive;
            reject_q <= e_reject;
            state_q  <= e_reject ? B_FIN : B_DIV1;
          end
        end
        B_DIV1: begin
          if (div_done) begin
            r_q     <= div_rem;
            state_q <= B_DIV2;
          end
        end
        B_DIV2: begin
          if (div_done) begin
            cyl_q   <= div_rem[CYL_W-1:0];
            state_q <= B_DIV3;
          end
        end
        B_DIV3: begin
          if (div_done) begin
            head_q   <= div_quo[HEAD_W-1:0];
            sector_q <= div_rem[SECT_W-1:0];
            state_q  <= B_FIN;
          end
        end
        B_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            oor_q       <= reject_q;
            if (reject_q) begin
              cylinder_q   <= '0;
              head_out_q   <= '0;
              sector_out_q <= '0;
              steps_q      <= '0;
              step_out_q   <= 1'b0;
              sel_q        <= '0;
            end else begin
              cylinder_q   <= cyl_q;
              head_out_q   <= head_q;
              sector_out_q <= sector_q;
              steps_q      <= steps;
              step_out_q   <= !up;
              sel_q        <= sel;
              track_q[drive_q[DrvIdxW-1:0]] <= cyl_q;
            end
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_of_range_o     = oor_q;
  assign cylinder_o         = cylinder_q;
  assign head_o             = head_out_q;
  assign sector_o           = sector_out_q;
  assign steps_o            = steps_q;
  assign step_out_o         = step_out_q;
  assign head_select_byte_o = sel_q;

endmodule

// ===== rtl/core/disk_block_to_seek_command.sv =====
// disk_block_to_seek_command: logical block to cylinder, head, sector and seek.
// Rejected requests skip the divisions. The front end can take a new request
// while the back end works on earlier ones; throughput is set by the three
// bit-serial divisions on the shared divider in the back end.
// Reset: async active low; geometry registers take their defaults, all stored
// tracks return to zero, queue and result register empty.
module disk_block_to_seek_command import dbsc_pkg::*; #(
  parameter int NUM_DRIVES = NUM_DRIVES_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DRIVE_W-1:0]    drive_i,
  input  logic [BLOCK_BITS-1:0] block_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_of_range_o,
  output logic [CYL_W-1:0]      cylinder_o,
  output logic [HEAD_W-1:0]     head_o,
  output logic [SECT_W-1:0]     sector_o,
  output logic [CYL_W-1:0]      steps_o,
  output logic                  step_out_o,
  output logic [SEL_W-1:0]      head_select_byte_o
);

  localparam int EntryW = BLOCK_BITS + 3;

  cfg_t              cfg_q;
  logic              push, pop, full, empty;
  logic [EntryW-1:0] push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.track_count       <= TRACK_COUNT_RST;
      cfg_q.head_count        <= HEAD_COUNT_RST;
      cfg_q.sectors_per_track <= SECTORS_PER_TRACK_RST;
      cfg_q.cylinder_rotation <= CYLINDER_ROTATION_RST;
      cfg_q.precomp_track     <= PRECOMP_TRACK_RST;
      cfg_q.low_current_track <= LOW_CURRENT_TRACK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TRACK_COUNT:       cfg_q.track_count       <= cfg_data_i;
        REG_HEAD_COUNT:        cfg_q.head_count        <= cfg_data_i[HEADS_W-1:0];
        REG_SECTORS_PER_TRACK: cfg_q.sectors_per_track <= cfg_data_i[SECT_W-1:0];
        REG_CYLINDER_ROTATION: cfg_q.cylinder_rotation <= cfg_data_i[ROT_W-1:0];
        REG_PRECOMP_TRACK:     cfg_q.precomp_track     <= cfg_data_i;
        REG_LOW_CURRENT_TRACK: cfg_q.low_current_track <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dbsc_front #(
    .NUM_DRIVES(NUM_DRIVES),
    .BLOCK_BITS(BLOCK_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .drive_i     (drive_i),
    .block_i     (block_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  dbsc_fifo #(
    .WIDTH(EntryW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  dbsc_back #(
    .NUM_DRIVES(NUM_DRIVES),
    .BLOCK_BITS(BLOCK_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .empty_i            (empty),
    .entry_i            (pop_data),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_of_range_o     (out_of_range_o),
    .cylinder_o         (cylinder_o),
    .head_o             (head_o),
    .sector_o           (sector_o),
    .steps_o            (steps_o),
    .step_out_o         (step_out_o),
    .head_select_byte_o (head_select_byte_o)
  );

endmodule

// ===== rtl/core/dbsc_checker.sv =====
// dbsc_checker: port-level checks on the translator, bound to the top level.
// Depends on dbsc_pkg for field widths.
module dbsc_checker import dbsc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              out_of_range_o,
  input logic [CYL_W-1:0]  cylinder_o,
  input logic [HEAD_W-1:0] head_o,
  input logic [SECT_W-1:0] sector_o,
  input logic [CYL_W-1:0]  steps_o,
  input logic              step_out_o,
  input logic [SEL_W-1:0]  head_select_byte_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cylinder_o) &&
      $stable(steps_o) && $stable(head_select_byte_o) && $stable(out_of_range_o))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("front took a second transfer at once");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> cylinder_o == '0 && head_o == '0 &&
      sector_o == '0 && steps_o == '0 && !step_out_o && head_select_byte_o == '0)
    else $error("rejected result carries data");

  a_head_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_of_range_o |->
      head_select_byte_o[4:2] == ~head_o && !head_select_byte_o[5])
    else $error("head select byte does not match head");

  a_equal_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_of_range_o && steps_o == '0 |-> step_out_o)
    else $error("zero steps without step out");

endmodule

bind disk_block_to_seek_command dbsc_checker u_dbsc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .out_of_range_o     (out_of_range_o),
  .cylinder_o         (cylinder_o),
  .head_o             (head_o),
  .sector_o           (sector_o),
  .steps_o            (steps_o),
  .step_out_o         (step_out_o),
  .head_select_byte_o (head_select_byte_o)
);
